// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brf assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define BRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brf assertion failed: next-cycle check");

`endif

// ===== hdl/brf_pkg.sv =====
// Package with types and constants of the byte ring FIFO line reader.
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_POP1   = 3'd1;
    localparam logic [OP_W-1:0] OP_DRAIN  = 3'd2;
    localparam logic [OP_W-1:0] OP_EXACT  = 3'd3;
    localparam logic [OP_W-1:0] OP_LINE   = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_LINE_END = 1'd0;

    localparam logic [BYTE_W-1:0] LINE_END_RESET = 8'd10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              success;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/byte_ring_fifo_line_reader_core.sv =====
// Top level of the byte ring FIFO line reader: config port and module wiring.
//
// Input channel (in_valid/in_ready): one word carries operation, in_byte and
// read_count. Insert stores in_byte unless the ring is full (then it is
// dropped); pop one, drain, exact count and line reads emit result words on
// the output channel (out_valid/out_ready), the final one with last set.
// Codes five to seven are accepted and ignored.
// Words pass a two-entry command queue to the engine, so input is taken
// while the engine works or a result waits. An insert is done by the engine
// in its idle state. A read that finds bytes fetches each one through the
// registered read port of the byte store before it shows it, one byte at a
// time; an empty or failed read answers straight from the idle state.
// A line read first scans, one byte per store read, up to the line end, or
// over every held byte when none is found.
// A stalled receiver holds the result register and the engine waits.
// Reset clears both ring indices, the queue and the output valid flag and sets
// line_end_char to 10; store contents stay undefined until written.
// line_end_char is written over the APB port at address 0.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo_line_reader_core
#(
    parameter int DEPTH = 64
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [brf_pkg::OP_W-1:0]      operation,
    input  wire logic [brf_pkg::BYTE_W-1:0]    in_byte,
    input  wire logic [brf_pkg::CNT_W-1:0]     read_count,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [brf_pkg::BYTE_W-1:0]         out_byte,
    output logic                               has_byte,
    output logic                               success,
    output logic                               last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [brf_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [brf_pkg::PDATA_W-1:0]   pwdata,
    output logic [brf_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    logic [brf_pkg::BYTE_W-1:0]    line_end_reg, line_end_next;
    logic [brf_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_wr;

    logic             q_ready;
    logic             q_push;
    brf_pkg::cmd_t    q_cmd;
    logic             cmd_valid;
    logic             cmd_pop;
    brf_pkg::cmd_t    cmd;
    brf_pkg::result_t res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[brf_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb
    begin
        line_end_next = line_end_reg;
        prdata        = '0;
        case (reg_idx)
            brf_pkg::REG_LINE_END:
            begin
                prdata = {{(brf_pkg::PDATA_W-brf_pkg::BYTE_W){1'b0}}, line_end_reg};
                if (cfg_wr)
                begin
                    line_end_next = pwdata[brf_pkg::BYTE_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_end_reg <= brf_pkg::LINE_END_RESET;
        end
        else
        begin
            line_end_reg <= line_end_next;
        end
    end

    brf_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .in_byte    (in_byte),
        .read_count (read_count),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    brf_cmd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .push_ready (q_ready),
        .pop        (cmd_pop),
        .pop_cmd    (cmd),
        .pop_valid  (cmd_valid)
    );

    brf_engine #(
        .DEPTH (DEPTH)
    ) u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .line_end_char (line_end_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .res           (res)
    );

    assign out_byte = res.out_byte;
    assign has_byte = res.has_byte;
    assign success  = res.success;
    assign last     = res.last;

endmodule

`default_nettype wire

// ===== hdl/brf_front.sv =====
// Front end: accepts input words, drops unknown operations, builds commands.
`timescale 1ns / 1ps
`default_nettype none

module brf_front
(
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [brf_pkg::OP_W-1:0]    operation,
    input  wire logic [brf_pkg::BYTE_W-1:0]  in_byte,
    input  wire logic [brf_pkg::CNT_W-1:0]   read_count,
    input  wire logic                        q_ready,
    output logic                             q_push,
    output brf_pkg::cmd_t                    q_cmd
);

    logic known_op;

    always_comb
    begin
        case (operation)
            brf_pkg::OP_INSERT,
            brf_pkg::OP_POP1,
            brf_pkg::OP_DRAIN,
            brf_pkg::OP_EXACT,
            brf_pkg::OP_LINE:  known_op = 1'b1;
            default:           known_op = 1'b0;
        endcase
    end

    assign in_ready    = q_ready;
    assign q_push      = in_valid & q_ready & known_op;
    assign q_cmd.op    = operation;
    assign q_cmd.data  = in_byte;
    assign q_cmd.count = read_count;

endmodule

`default_nettype wire

// ===== hdl/brf_cmd_queue.sv =====
// Two-entry command queue between the front end and the FIFO engine.
`timescale 1ns / 1ps
`default_nettype none

module brf_cmd_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire brf_pkg::cmd_t  push_cmd,
    output logic                push_ready,
    input  wire logic           pop,
    output brf_pkg::cmd_t       pop_cmd,
    output logic                pop_valid
);

    brf_pkg::cmd_t                entry_reg [brf_pkg::QDEPTH];
    logic [brf_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [brf_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [brf_pkg::QPTR_W:0]     count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (count_reg != (brf_pkg::QPTR_W+1)'(brf_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/brf_engine.sv =====
// FIFO engine: byte ring store, indices, read sequencing and result register.
`timescale 1ns / 1ps
`default_nettype none

module brf_engine
#(
    parameter int DEPTH = 64
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    input  wire brf_pkg::cmd_t               cmd,
    output logic                             cmd_pop,
    input  wire logic [brf_pkg::BYTE_W-1:0]  line_end_char,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output brf_pkg::result_t                 res
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_RD_ADDR   = 3'd1;
    localparam logic [2:0] ST_RD_OUT    = 3'd2;
    localparam logic [2:0] ST_SCAN_ADDR = 3'd3;
    localparam logic [2:0] ST_SCAN_CHK  = 3'd4;

    logic [brf_pkg::BYTE_W-1:0] store_mem [DEPTH];
    logic [brf_pkg::BYTE_W-1:0] rdata_reg;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] remain_reg, remain_next;
    logic [IDX_W-1:0] scan_pos_reg, scan_pos_next;
    logic [IDX_W-1:0] scan_k_reg, scan_k_next;
    logic             line_mode_reg, line_mode_next;
    logic             out_valid_reg, out_valid_next;
    brf_pkg::result_t res_reg, res_next;

    logic [IDX_W:0]             held_wide;
    logic [IDX_W-1:0]           held;
    logic [brf_pkg::CNT_W-1:0]  held_cnt;
    logic [IDX_W-1:0]           rd_addr;
    logic                       out_free;
    logic                       mem_we;
    logic [IDX_W-1:0]           wr_idx_inc;

    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign held_wide = (wr_idx_reg >= rd_idx_reg)
                     ? ({1'b0, wr_idx_reg} - {1'b0, rd_idx_reg})
                     : ({1'b0, wr_idx_reg} + (IDX_W+1)'(DEPTH) - {1'b0, rd_idx_reg});
    assign held      = held_wide[IDX_W-1:0];
    assign held_cnt  = brf_pkg::CNT_W'(held);
    assign out_free  = !out_valid_reg || out_ready;
    assign rd_addr   = (state_reg == ST_SCAN_ADDR || state_reg == ST_SCAN_CHK)
                     ? scan_pos_reg : rd_idx_reg;
    assign wr_idx_inc = inc_idx(wr_idx_reg);
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        remain_next    = remain_reg;
        scan_pos_next  = scan_pos_reg;
        scan_k_next    = scan_k_reg;
        line_mode_next = line_mode_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == brf_pkg::OP_INSERT)
                    begin
                        cmd_pop = 1'b1;
                        if (wr_idx_inc != rd_idx_reg)
                        begin
                            mem_we      = 1'b1;
                            wr_idx_next = wr_idx_inc;
                        end
                    end
                    else if (out_free)
                    begin
                        cmd_pop        = 1'b1;
                        line_mode_next = 1'b0;
                        if (held == '0 || (cmd.op == brf_pkg::OP_EXACT &&
                            (cmd.count == '0 || cmd.count > held_cnt)))
                        begin
                            out_valid_next = 1'b1;
                            res_next       = '{out_byte: '0, has_byte: 1'b0,
                                               success: 1'b0, last: 1'b1};
                        end
                        else
                        begin
                            case (cmd.op)
                                brf_pkg::OP_POP1:
                                begin
                                    remain_next = IDX_W'(1);
                                    state_next  = ST_RD_ADDR;
                                end
                                brf_pkg::OP_DRAIN:
                                begin
                                    remain_next = held;
                                    state_next  = ST_RD_ADDR;
                                end
                                brf_pkg::OP_EXACT:
                                begin
                                    remain_next = IDX_W'(cmd.count);
                                    state_next  = ST_RD_ADDR;
                                end
                                brf_pkg::OP_LINE:
                                begin
                                    scan_pos_next = rd_idx_reg;
                                    scan_k_next   = '0;
                                    state_next    = ST_SCAN_ADDR;
                                end
                                default:
                                begin
                                    state_next = ST_IDLE;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    res_next       = '{out_byte: rdata_reg, has_byte: 1'b1,
                                       success: 1'b1, last: (remain_reg == IDX_W'(1))};
                    if (remain_reg == IDX_W'(1))
                    begin
                        rd_idx_next = line_mode_reg ? inc_idx(inc_idx(rd_idx_reg))
                                                    : inc_idx(rd_idx_reg);
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = inc_idx(rd_idx_reg);
                        remain_next = remain_reg - 1'b1;
                        state_next  = ST_RD_ADDR;
                    end
                end
            end
            ST_SCAN_ADDR:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (rdata_reg == line_end_char)
                begin
                    if (scan_k_reg == '0)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            res_next       = '{out_byte: '0, has_byte: 1'b0,
                                               success: 1'b1, last: 1'b1};
                            rd_idx_next    = inc_idx(rd_idx_reg);
                            state_next     = ST_IDLE;
                        end
                    end
                    else
                    begin
                        remain_next    = scan_k_reg;
                        line_mode_next = 1'b1;
                        state_next     = ST_RD_ADDR;
                    end
                end
                else if (scan_k_reg + 1'b1 == held)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        res_next       = '{out_byte: '0, has_byte: 1'b0,
                                           success: 1'b0, last: 1'b1};
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    scan_k_next   = scan_k_reg + 1'b1;
                    scan_pos_next = inc_idx(scan_pos_reg);
                    state_next    = ST_SCAN_ADDR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            remain_reg    <= '0;
            scan_pos_reg  <= '0;
            scan_k_reg    <= '0;
            line_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            remain_reg    <= remain_next;
            scan_pos_reg  <= scan_pos_next;
            scan_k_reg    <= scan_k_next;
            line_mode_reg <= line_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_idx_reg] <= cmd.data;
        end
        rdata_reg <= store_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/brf_checker.sv =====
// Port-level checker for the byte ring FIFO line reader, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module brf_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [brf_pkg::BYTE_W-1:0]    out_byte,
    input wire logic                          has_byte,
    input wire logic                          success,
    input wire logic                          last,
    input wire logic                          pready
);

    `BRF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `BRF_ASSERT_IMP(a_byte_ok, clk, rst_n, out_valid && has_byte, success)
    `BRF_ASSERT_IMP(a_empty_last, clk, rst_n, out_valid && !has_byte, last && out_byte == '0)
    `BRF_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)

endmodule

bind byte_ring_fifo_line_reader_core brf_checker u_brf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .success   (success),
    .last      (last),
    .pready    (pready)
);

`default_nettype wire

// ===== dv/byte_ring_fifo_line_reader_core_test.sv =====
// Self-checking testbench for the byte ring FIFO line reader core.
`timescale 1ns / 1ps

module byte_ring_fifo_line_reader_core_test;

    localparam int RING_SLOTS = 64;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;

    class byte_ring_mirror;
        logic [brf_pkg::BYTE_W-1:0] ring [RING_SLOTS];
        int unsigned                wr_pos;
        int unsigned                rd_pos;
        logic [brf_pkg::BYTE_W-1:0] line_end;
        brf_pkg::result_t           expected_words [$];
        int                         errors;

        function new();
            wr_pos   = 0;
            rd_pos   = 0;
            line_end = brf_pkg::LINE_END_RESET;
            errors   = 0;
        endfunction

        function int unsigned held();
            return (wr_pos + RING_SLOTS - rd_pos) % RING_SLOTS;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void push_word(logic [brf_pkg::BYTE_W-1:0] value, logic has, logic ok,
                                logic fin);
            brf_pkg::result_t word;
            word.out_byte = value;
            word.has_byte = has;
            word.success  = ok;
            word.last     = fin;
            expected_words.push_back(word);
        endfunction

        function void pop_bytes(int unsigned n);
            for (int unsigned k = 0; k < n; k++)
            begin
                push_word(ring[rd_pos], 1'b1, 1'b1, k + 1 == n);
                rd_pos = (rd_pos + 1) % RING_SLOTS;
            end
        endfunction

        function void take_command(logic [brf_pkg::OP_W-1:0] op,
                                   logic [brf_pkg::BYTE_W-1:0] data,
                                   logic [brf_pkg::CNT_W-1:0] count);
            int unsigned n;
            int unsigned k;
            int unsigned pos;
            bit          found;
            n = held();
            case (op)
                brf_pkg::OP_INSERT:
                begin
                    if ((wr_pos + 1) % RING_SLOTS != rd_pos)
                    begin
                        ring[wr_pos] = data;
                        wr_pos = (wr_pos + 1) % RING_SLOTS;
                    end
                end
                brf_pkg::OP_POP1:
                begin
                    if (n == 0)
                        push_word(8'd0, 1'b0, 1'b0, 1'b1);
                    else
                        pop_bytes(1);
                end
                brf_pkg::OP_DRAIN:
                begin
                    if (n == 0)
                        push_word(8'd0, 1'b0, 1'b0, 1'b1);
                    else
                        pop_bytes(n);
                end
                brf_pkg::OP_EXACT:
                begin
                    if (count == 0 || count > n)
                        push_word(8'd0, 1'b0, 1'b0, 1'b1);
                    else
                        pop_bytes(32'(count));
                end
                brf_pkg::OP_LINE:
                begin
                    found = 1'b0;
                    pos   = rd_pos;
                    k     = 0;
                    while (k < n && !found)
                    begin
                        if (ring[pos] == line_end)
                            found = 1'b1;
                        else
                        begin
                            pos = (pos + 1) % RING_SLOTS;
                            k++;
                        end
                    end
                    if (!found)
                        push_word(8'd0, 1'b0, 1'b0, 1'b1);
                    else if (k == 0)
                    begin
                        rd_pos = (rd_pos + 1) % RING_SLOTS;
                        push_word(8'd0, 1'b0, 1'b1, 1'b1);
                    end
                    else
                    begin
                        pop_bytes(k);
                        rd_pos = (rd_pos + 1) % RING_SLOTS;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_word(brf_pkg::result_t got);
            brf_pkg::result_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: byte %0h has %0b ok %0b last %0b",
                             got.out_byte, got.has_byte, got.success, got.last);
                return;
            end
            want = expected_words.pop_front();
            if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                got.success !== want.success || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected byte %0h has %0b ok %0b last %0b,",
                              " got byte %0h has %0b ok %0b last %0b"},
                             want.out_byte, want.has_byte, want.success, want.last,
                             got.out_byte, got.has_byte, got.success, got.last);
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [brf_pkg::OP_W-1:0]     operation;
    logic [brf_pkg::BYTE_W-1:0]   in_byte;
    logic [brf_pkg::CNT_W-1:0]    read_count;
    logic                         out_valid;
    logic                         out_ready;
    logic [brf_pkg::BYTE_W-1:0]   out_byte;
    logic                         has_byte;
    logic                         success;
    logic                         last;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [brf_pkg::PADDR_W-1:0]  paddr;
    logic [brf_pkg::PDATA_W-1:0]  pwdata;
    logic [brf_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    byte_ring_mirror board;
    int unsigned     in_idle_pct;
    int unsigned     out_idle_pct;
    int unsigned     stall_cycles;

    byte_ring_fifo_line_reader_core #(.DEPTH(RING_SLOTS)) uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .in_byte    (in_byte),
        .read_count (read_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .success    (success),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin : watch_results
        brf_pkg::result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.out_byte = out_byte;
            got.has_byte = has_byte;
            got.success  = success;
            got.last     = last;
            board.check_word(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable && pready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [brf_pkg::OP_W-1:0] op,
                             input logic [brf_pkg::BYTE_W-1:0] data,
                             input logic [brf_pkg::CNT_W-1:0] count);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        operation  = op;
        in_byte    = data;
        read_count = count;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        board.take_command(op, data, count);
    endtask

    task automatic send_read(input logic [brf_pkg::OP_W-1:0] op,
                             input logic [brf_pkg::CNT_W-1:0] count);
        send_word(op, brf_pkg::BYTE_W'($urandom_range(255)), count);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_line_end(input logic [brf_pkg::BYTE_W-1:0] value);
        settle();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {brf_pkg::REG_LINE_END, 2'b00};
        pwdata  = {{(brf_pkg::PDATA_W-brf_pkg::BYTE_W){1'b0}}, value};
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        board.line_end = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned                done_items;
        int unsigned                burst;
        int unsigned                roll;
        int unsigned                n;
        logic [brf_pkg::OP_W-1:0]   op;
        logic [brf_pkg::BYTE_W-1:0] data;
        logic [brf_pkg::CNT_W-1:0]  cnt;
        done_items = 0;
        burst      = 0;
        while (done_items < count)
        begin
            n    = board.held();
            data = brf_pkg::BYTE_W'($urandom_range(255));
            cnt  = brf_pkg::CNT_W'($urandom_range(64));
            roll = $urandom_range(99);
            if (burst == 0 && roll < 6)
                burst = $urandom_range(8, 70);
            if (burst != 0)
            begin
                op = brf_pkg::OP_INSERT;
                burst--;
            end
            else if (roll < 50)
                op = brf_pkg::OP_INSERT;
            else if (roll < 60)
                op = brf_pkg::OP_POP1;
            else if (roll < 64)
                op = brf_pkg::OP_DRAIN;
            else if (roll < 77)
                op = brf_pkg::OP_EXACT;
            else if (roll < 95)
                op = brf_pkg::OP_LINE;
            else
                op = brf_pkg::OP_W'($urandom_range(5, 7));
            if (op == brf_pkg::OP_INSERT && $urandom_range(99) < 18)
                data = board.line_end;
            if (op == brf_pkg::OP_EXACT)
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    cnt = brf_pkg::CNT_W'($urandom_range(1, (n == 0) ? 1 : n));
                else if (roll < 80)
                    cnt = '0;
                else if (roll < 90)
                    cnt = brf_pkg::CNT_W'(n + 1);
            end
            send_word(op, data, cnt);
            done_items++;
        end
    endtask

    initial
    begin
        board        = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = brf_pkg::OP_INSERT;
        in_byte      = '0;
        read_count   = '0;
        out_ready    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        stall_cycles = 0;
        in_idle_pct  = 26;
        out_idle_pct = 26;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_read(brf_pkg::OP_POP1, 7'd0);
        send_read(brf_pkg::OP_DRAIN, 7'd64);
        send_read(brf_pkg::OP_EXACT, 7'd0);
        send_read(brf_pkg::OP_LINE, 7'd1);
        send_read(3'd5, 7'd64);
        send_read(3'd6, 7'd127);
        send_read(3'd7, 7'd0);
        send_word(brf_pkg::OP_INSERT, 8'h00, 7'd64);
        send_word(brf_pkg::OP_INSERT, 8'hFF, 7'd0);
        send_word(brf_pkg::OP_INSERT, brf_pkg::LINE_END_RESET, 7'd127);
        send_word(brf_pkg::OP_INSERT, brf_pkg::LINE_END_RESET, 7'd0);
        send_word(brf_pkg::OP_INSERT, 8'h55, 7'd42);
        send_word(brf_pkg::OP_INSERT, 8'hAA, 7'd21);
        send_read(brf_pkg::OP_LINE, 7'd0);
        send_read(brf_pkg::OP_LINE, 7'd127);
        send_read(brf_pkg::OP_EXACT, 7'd0);
        send_read(brf_pkg::OP_EXACT, 7'd64);
        send_read(brf_pkg::OP_LINE, 7'd5);
        send_read(brf_pkg::OP_POP1, 7'd127);
        send_word(brf_pkg::OP_INSERT, 8'h7F, 7'd0);
        send_word(brf_pkg::OP_INSERT, 8'h80, 7'd0);
        send_read(brf_pkg::OP_EXACT, 7'd2);
        send_read(brf_pkg::OP_DRAIN, 7'd0);

        write_line_end(8'h00);
        run_random(110);
        write_line_end(8'hFF);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random(110);
        in_idle_pct  = 26;
        out_idle_pct = 26;
        write_line_end(brf_pkg::BYTE_W'($urandom_range(255)));
        run_random(110);
        write_line_end(brf_pkg::LINE_END_RESET);
        run_random(110);
        settle();

        if (board.errors == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
